// File: hw/rtl/rwct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_pkg: shared types and constants of the wall column texel generator
// Texture codes, hit kinds, side colors, register map and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rwct_pkg;

    // Field widths fixed by the interface
    localparam int COL_W    = 10;
    localparam int ROW_W    = 6;
    localparam int ROWCNT_W = ROW_W + 1;
    localparam int KIND_W   = 2;
    localparam int SIGN_W   = 2;
    localparam int LH_W     = 16;
    localparam int WF_W     = 16;
    localparam int TSIZE_W  = 11;
    localparam int SCRH_W   = 7;
    localparam int ID_W     = 3;
    localparam int TEX_W    = 10;
    localparam int COLOR_W  = 24;
    localparam int OFF_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Texture identifiers
    localparam logic [ID_W-1:0] TEX_WEST  = 3'd0;
    localparam logic [ID_W-1:0] TEX_EAST  = 3'd1;
    localparam logic [ID_W-1:0] TEX_NORTH = 3'd2;
    localparam logic [ID_W-1:0] TEX_SOUTH = 3'd3;
    localparam logic [ID_W-1:0] TEX_ENEMY = 3'd4;

    // Hit kinds
    localparam logic [KIND_W-1:0] KIND_WALL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENEMY = 2'd1;

    // Direction sign encodings (two-bit signed)
    localparam logic [SIGN_W-1:0] SIGN_POS = 2'b01;

    // Flat side colors
    localparam logic [COLOR_W-1:0] COLOR_X_POS = 24'hFF0000;
    localparam logic [COLOR_W-1:0] COLOR_X_NEG = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_Y_POS = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] COLOR_Y_NEG = 24'h00FF00;

    // Register map (index = byte address / 4)
    localparam logic REG_TEXTURE_SIZE  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd64;
    localparam logic [SCRH_W-1:0]  SCRH_RESET  = 7'd64;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch request fields
        logic prep;       // texture choice, run length, offset, texel_x product
        logic fix;        // finish texel_x, start step division
        logic take_step;  // latch saturated step
        logic scale;      // start position = offset * step
        logic emit;       // load output register with next row
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic textured;
        logic empty;
        logic div_done;
        logic out_free;
        logic last_one;
    } status_t;

endpackage

// File: hw/rtl/rwct_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_div: restoring unsigned divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwct_div #(
    parameter int DVD_W = 27,
    parameter int DSR_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[DSR_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DSR_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: hw/rtl/rwct_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_dpath: column datapath
// Holds the request, picks the texture, computes texel_x, step, start
// position and steps the texture position row by row into the output register.
// ----------------------------------------------------------------------------
module rwct_dpath #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rwct_pkg::cmd_t                       cmd,
    output rwct_pkg::status_t                    status,
    // configuration
    input  logic [rwct_pkg::TSIZE_W-1:0]         texture_size,
    input  logic [rwct_pkg::SCRH_W-1:0]          screen_height,
    // request fields
    input  logic [rwct_pkg::COL_W-1:0]           column,
    input  logic                                 hit_side,
    input  logic signed [rwct_pkg::SIGN_W-1:0]   ray_x_sign,
    input  logic signed [rwct_pkg::SIGN_W-1:0]   ray_y_sign,
    input  logic                                 step_x_positive,
    input  logic                                 step_y_positive,
    input  logic [rwct_pkg::KIND_W-1:0]          hit_kind,
    input  logic [rwct_pkg::LH_W-1:0]            wall_height,
    input  logic [rwct_pkg::ROW_W-1:0]           row_start,
    input  logic [rwct_pkg::ROW_W-1:0]           row_end,
    input  logic [rwct_pkg::WF_W-1:0]            wall_fraction,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rwct_pkg::COL_W-1:0]           out_column,
    output logic [rwct_pkg::ROW_W-1:0]           out_row,
    output logic                                 flat_fill,
    output logic [rwct_pkg::ID_W-1:0]            texture_id,
    output logic [rwct_pkg::TEX_W-1:0]           texel_x,
    output logic [rwct_pkg::TEX_W-1:0]           texel_y,
    output logic [rwct_pkg::COLOR_W-1:0]         flat_color,
    output logic                                 last_pixel
);

    localparam int POS_W   = rwct_pkg::TEX_W + FRAC_BITS;
    localparam int DVD_W   = rwct_pkg::TSIZE_W + FRAC_BITS;
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int PROD_W  = rwct_pkg::WF_W + rwct_pkg::TSIZE_W;
    localparam int SCALE_W = rwct_pkg::OFF_W + POS_W;
    localparam logic [rwct_pkg::ROWCNT_W-1:0] MAX_CNT = rwct_pkg::ROWCNT_W'(MAX_ROWS);

    // Request registers
    logic [rwct_pkg::COL_W-1:0]  col_reg;
    logic                        side_reg;
    logic [rwct_pkg::SIGN_W-1:0] rx_reg, ry_reg;
    logic                        spx_reg, spy_reg;
    logic [rwct_pkg::KIND_W-1:0] kind_reg;
    logic [rwct_pkg::LH_W-1:0]   lh_reg;
    logic [rwct_pkg::ROW_W-1:0]  rs_reg, re_reg;
    logic [rwct_pkg::WF_W-1:0]   wf_reg;

    // Column setup registers
    logic                         textured_reg;
    logic                         mirror_reg;
    logic [rwct_pkg::ID_W-1:0]    id_reg;
    logic [rwct_pkg::COLOR_W-1:0] color_reg;
    logic [rwct_pkg::OFF_W-1:0]   offset_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [rwct_pkg::TEX_W-1:0]   lim_reg;
    logic [rwct_pkg::TEX_W-1:0]   tx_reg;
    logic [POS_W-1:0]             step_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [rwct_pkg::ROW_W-1:0]   row_reg;
    logic [CNT_W-1:0]             left_reg;

    // Output register
    logic                         ov_reg;
    logic [rwct_pkg::COL_W-1:0]   o_col_reg;
    logic [rwct_pkg::ROW_W-1:0]   o_row_reg;
    logic                         o_flat_reg;
    logic [rwct_pkg::ID_W-1:0]    o_id_reg;
    logic [rwct_pkg::TEX_W-1:0]   o_tx_reg;
    logic [rwct_pkg::TEX_W-1:0]   o_ty_reg;
    logic [rwct_pkg::COLOR_W-1:0] o_color_reg;
    logic                         o_last_reg;

    // Setup logic
    logic                          rx_pos, rx_neg, ry_pos, ry_neg;
    logic                          tex_sel;
    logic [rwct_pkg::ID_W-1:0]     id_sel;
    logic [rwct_pkg::COLOR_W-1:0]  color_sel;
    logic [rwct_pkg::ROWCNT_W-1:0] cnt_raw;
    logic [CNT_W-1:0]              cnt_sel;
    logic [rwct_pkg::OFF_W-1:0]    base_pos;
    logic [rwct_pkg::OFF_W-1:0]    half_h;
    logic [rwct_pkg::OFF_W-1:0]    off_sel;
    logic [rwct_pkg::TSIZE_W-1:0]  lim_full;
    logic [rwct_pkg::TEX_W-1:0]    lim_sel;

    // texel_x finish
    logic [rwct_pkg::TSIZE_W-1:0]  tx_raw;
    logic [rwct_pkg::TSIZE_W-1:0]  tx_mir;
    logic [rwct_pkg::TEX_W-1:0]    tx_sel;

    // Division, scaling, stepping
    logic [DVD_W-1:0]              div_q;
    logic                          div_done;
    logic [DVD_W-1:0]              dividend;
    logic [rwct_pkg::LH_W-1:0]     divisor;
    logic [POS_W-1:0]              step_sat;
    logic [SCALE_W-1:0]            scaled;
    logic [POS_W-1:0]              pos_start;
    logic [POS_W:0]                pos_sum;
    logic [POS_W-1:0]              pos_adv;
    logic [rwct_pkg::TEX_W-1:0]    ty_raw;
    logic [rwct_pkg::TEX_W-1:0]    ty_sel;

    // Texture choice, flat color, run length, start offset, texel limit
    always_comb
    begin
        rx_pos  = (rx_reg == rwct_pkg::SIGN_POS);
        rx_neg  = rx_reg[rwct_pkg::SIGN_W-1];
        ry_pos  = (ry_reg == rwct_pkg::SIGN_POS);
        ry_neg  = ry_reg[rwct_pkg::SIGN_W-1];
        tex_sel = 1'b0;
        id_sel  = rwct_pkg::TEX_WEST;
        if (kind_reg == rwct_pkg::KIND_WALL)
        begin
            if (!side_reg && rx_pos)
            begin
                tex_sel = 1'b1;
                id_sel  = rwct_pkg::TEX_WEST;
            end
            else if (!side_reg && rx_neg)
            begin
                tex_sel = 1'b1;
                id_sel  = rwct_pkg::TEX_EAST;
            end
            else if (side_reg && ry_pos)
            begin
                tex_sel = 1'b1;
                id_sel  = rwct_pkg::TEX_NORTH;
            end
            else if (side_reg && ry_neg)
            begin
                tex_sel = 1'b1;
                id_sel  = rwct_pkg::TEX_SOUTH;
            end
        end
        else if (kind_reg == rwct_pkg::KIND_ENEMY)
        begin
            tex_sel = 1'b1;
            id_sel  = rwct_pkg::TEX_ENEMY;
        end

        if (!side_reg)
            color_sel = spx_reg ? rwct_pkg::COLOR_X_POS : rwct_pkg::COLOR_X_NEG;
        else
            color_sel = spy_reg ? rwct_pkg::COLOR_Y_POS : rwct_pkg::COLOR_Y_NEG;

        // textured runs are inclusive of row_end, flat runs are not
        if (tex_sel)
            cnt_raw = (re_reg >= rs_reg)
                    ? rwct_pkg::ROWCNT_W'(re_reg) - rwct_pkg::ROWCNT_W'(rs_reg) + 1'b1
                    : '0;
        else
            cnt_raw = (re_reg > rs_reg)
                    ? rwct_pkg::ROWCNT_W'(re_reg) - rwct_pkg::ROWCNT_W'(rs_reg)
                    : '0;
        cnt_sel = (cnt_raw > MAX_CNT) ? CNT_W'(MAX_ROWS) : CNT_W'(cnt_raw);

        // offset = row_start + lh/2 - screen_height/2, floored at zero
        base_pos = rwct_pkg::OFF_W'(rs_reg) + rwct_pkg::OFF_W'(lh_reg[rwct_pkg::LH_W-1:1]);
        half_h   = rwct_pkg::OFF_W'(screen_height[rwct_pkg::SCRH_W-1:1]);
        off_sel  = (base_pos > half_h) ? base_pos - half_h : '0;

        // texel limit: texture_size - 1, at most 1023, zero for an empty texture
        lim_full = (texture_size == '0) ? '0 : texture_size - 1'b1;
        lim_sel  = (lim_full > rwct_pkg::TSIZE_W'({rwct_pkg::TEX_W{1'b1}}))
                 ? {rwct_pkg::TEX_W{1'b1}} : lim_full[rwct_pkg::TEX_W-1:0];
    end

    // texel_x: mirror then clamp
    always_comb
    begin
        tx_raw = prod_reg[PROD_W-1:rwct_pkg::WF_W];
        if (mirror_reg)
            tx_mir = (texture_size > tx_raw) ? texture_size - 1'b1 - tx_raw : '0;
        else
            tx_mir = tx_raw;
        tx_sel = (tx_mir > rwct_pkg::TSIZE_W'(lim_reg)) ? lim_reg
               : tx_mir[rwct_pkg::TEX_W-1:0];
    end

    // Step division operands
    assign dividend = {texture_size, {FRAC_BITS{1'b0}}};
    assign divisor  = (lh_reg == '0) ? rwct_pkg::LH_W'(1) : lh_reg;

    rwct_div #(
        .DVD_W (DVD_W),
        .DSR_W (rwct_pkg::LH_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.fix),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Saturations of step, start position and per-row advance
    always_comb
    begin
        step_sat  = (div_q[DVD_W-1:POS_W] != '0) ? {POS_W{1'b1}} : div_q[POS_W-1:0];
        scaled    = SCALE_W'(offset_reg) * SCALE_W'(step_reg);
        pos_start = (scaled[SCALE_W-1:POS_W] != '0) ? {POS_W{1'b1}} : scaled[POS_W-1:0];
        pos_sum   = {1'b0, pos_reg} + {1'b0, step_reg};
        pos_adv   = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
        ty_raw    = pos_reg[POS_W-1:FRAC_BITS];
        ty_sel    = (ty_raw > lim_reg) ? lim_reg : ty_raw;
    end

    // Request and setup registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg  <= column;
            side_reg <= hit_side;
            rx_reg   <= ray_x_sign;
            ry_reg   <= ray_y_sign;
            spx_reg  <= step_x_positive;
            spy_reg  <= step_y_positive;
            kind_reg <= hit_kind;
            lh_reg   <= wall_height;
            rs_reg   <= row_start;
            re_reg   <= row_end;
            wf_reg   <= wall_fraction;
        end
        if (cmd.prep)
        begin
            textured_reg <= tex_sel;
            mirror_reg   <= (!side_reg && rx_pos) || (side_reg && ry_neg);
            id_reg       <= id_sel;
            color_reg    <= color_sel;
            offset_reg   <= off_sel;
            prod_reg     <= PROD_W'(wf_reg) * PROD_W'(texture_size);
            lim_reg      <= lim_sel;
            row_reg      <= rs_reg;
            left_reg     <= cnt_sel;
        end
        if (cmd.fix)
            tx_reg <= tx_sel;
        if (cmd.take_step)
            step_reg <= step_sat;
        if (cmd.scale)
            pos_reg <= pos_start;
        if (cmd.emit)
        begin
            row_reg  <= row_reg + 1'b1;
            left_reg <= left_reg - 1'b1;
            pos_reg  <= pos_adv;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_col_reg   <= col_reg;
            o_row_reg   <= row_reg;
            o_flat_reg  <= !textured_reg;
            o_id_reg    <= textured_reg ? id_reg : '0;
            o_tx_reg    <= textured_reg ? tx_reg : '0;
            o_ty_reg    <= textured_reg ? ty_sel : '0;
            o_color_reg <= textured_reg ? '0 : color_reg;
            o_last_reg  <= (left_reg == CNT_W'(1));
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    assign status.textured = textured_reg;
    assign status.empty    = (left_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = !ov_reg || out_ready;
    assign status.last_one = (left_reg == CNT_W'(1));

    assign out_valid  = ov_reg;
    assign out_column = o_col_reg;
    assign out_row    = o_row_reg;
    assign flat_fill  = o_flat_reg;
    assign texture_id = o_id_reg;
    assign texel_x    = o_tx_reg;
    assign texel_y    = o_ty_reg;
    assign flat_color = o_color_reg;
    assign last_pixel = o_last_reg;

endmodule

// File: hw/rtl/rwct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwct_ctrl: column sequencer
// Steps each request through setup, step division and start scaling (textured
// columns only) and the per-row emit loop.
// ----------------------------------------------------------------------------
module rwct_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rwct_pkg::status_t  status,
    output rwct_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FIX,
        ST_DIVW,
        ST_SCALE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix = 1'b1;
                priority if (status.empty)
                    state_next = ST_IDLE;
                else if (status.textured)
                    state_next = ST_DIVW;
                else
                    state_next = ST_EMIT;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.take_step = 1'b1;
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_one)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hw/rtl/raycast_wall_column_texel_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_wall_column_texel_gen: textured wall column texel address generator
// Takes one cast column per request and emits one texel address (or flat
// side color) per drawn row.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction  Moves
//  in        in_valid / in_ready + fields     sink       one column request
//  out       out_valid / out_ready + fields   source     one row result
//  cfg       psel/penable/pwrite/paddr/...    slave      register access
//
//  Sequence: accept, setup (prep and fix), then for textured columns the
//  bit-serial step divider, the step latch and start scaling, then one row
//  per cycle while out_ready does not stall the output register. Flat
//  columns skip the divider, which sets the per-column overhead.
//  Reset: rst_n asynchronous; registers return to texture_size 64 and
//  screen_height 64. A new request is taken while the final row still waits
//  in the output register; a stalled out_ready holds the row loop.
// ----------------------------------------------------------------------------
module raycast_wall_column_texel_gen #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rwct_pkg::COL_W-1:0]          column,
    input  logic                                hit_side,
    input  logic signed [rwct_pkg::SIGN_W-1:0]  ray_x_sign,
    input  logic signed [rwct_pkg::SIGN_W-1:0]  ray_y_sign,
    input  logic                                step_x_positive,
    input  logic                                step_y_positive,
    input  logic [rwct_pkg::KIND_W-1:0]         hit_kind,
    input  logic [rwct_pkg::LH_W-1:0]           wall_height,
    input  logic [rwct_pkg::ROW_W-1:0]          row_start,
    input  logic [rwct_pkg::ROW_W-1:0]          row_end,
    input  logic [rwct_pkg::WF_W-1:0]           wall_fraction,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rwct_pkg::COL_W-1:0]          out_column,
    output logic [rwct_pkg::ROW_W-1:0]          out_row,
    output logic                                flat_fill,
    output logic [rwct_pkg::ID_W-1:0]           texture_id,
    output logic [rwct_pkg::TEX_W-1:0]          texel_x,
    output logic [rwct_pkg::TEX_W-1:0]          texel_y,
    output logic [rwct_pkg::COLOR_W-1:0]        flat_color,
    output logic                                last_pixel,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rwct_pkg::ADDR_W-1:0]         paddr,
    input  logic [rwct_pkg::DATA_W-1:0]         pwdata,
    output logic [rwct_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    logic [rwct_pkg::TSIZE_W-1:0] tsize_reg;
    logic [rwct_pkg::SCRH_W-1:0]  scrh_reg;
    logic                         reg_sel;
    rwct_pkg::cmd_t               cmd;
    rwct_pkg::status_t            status;

    // Register decode on the word address bit
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg <= rwct_pkg::TSIZE_RESET;
            scrh_reg  <= rwct_pkg::SCRH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                rwct_pkg::REG_TEXTURE_SIZE:  tsize_reg <= pwdata[rwct_pkg::TSIZE_W-1:0];
                rwct_pkg::REG_SCREEN_HEIGHT: scrh_reg  <= pwdata[rwct_pkg::SCRH_W-1:0];
                default:                     tsize_reg <= tsize_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            rwct_pkg::REG_TEXTURE_SIZE:  prdata = rwct_pkg::DATA_W'(tsize_reg);
            rwct_pkg::REG_SCREEN_HEIGHT: prdata = rwct_pkg::DATA_W'(scrh_reg);
            default:                     prdata = '0;
        endcase
    end

    rwct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rwct_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .texture_size    (tsize_reg),
        .screen_height   (scrh_reg),
        .column          (column),
        .hit_side        (hit_side),
        .ray_x_sign      (ray_x_sign),
        .ray_y_sign      (ray_y_sign),
        .step_x_positive (step_x_positive),
        .step_y_positive (step_y_positive),
        .hit_kind        (hit_kind),
        .wall_height     (wall_height),
        .row_start       (row_start),
        .row_end         (row_end),
        .wall_fraction   (wall_fraction),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_column      (out_column),
        .out_row         (out_row),
        .flat_fill       (flat_fill),
        .texture_id      (texture_id),
        .texel_x         (texel_x),
        .texel_y         (texel_y),
        .flat_color      (flat_color),
        .last_pixel      (last_pixel)
    );

endmodule
